// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Antecedent implies that the signal holds its value into the next cycle.
`define ASSERT_HOLD(lbl, clk, rstn, ante, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> $stable(sig)) \
    else $error("assertion failed: signal changed");

`endif

// ===== sv/dit_pkg.sv =====
// Package: sizes and controller/datapath interface types of the interval tracker.
package dit_pkg;

  localparam int MAX_RANGES = 16;
  localparam int VAL_W      = 32;
  // Count holds 0..MAX_RANGES; index addresses one table entry.
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture value, rewind index, clear drop flag
    logic step;     // advance scan index
    logic resolve;  // extend, insert or drop at the scan position
    logic merge;    // fold the following interval in if it now touches
    logic emit;     // present one table entry on the result ports
  } dit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;  // entry at index ends well below the value
    logic hit;        // value lies in or touches the entry at index
    logic last;       // index is the final stored entry
  } dit_status_t;

endpackage

// ===== sv/dit_datapath.sv =====
// Datapath: interval tables, scan index, update logic and result registers.
module dit_datapath
  import dit_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dit_cmd_t          cmd_i,
  output dit_status_t       status_o,
  input  logic [VAL_W-1:0]  value_i,
  output logic              result_valid_o,
  output logic [VAL_W-1:0]  range_start_o,
  output logic [VAL_W-1:0]  range_end_o,
  output logic              last_range_o,
  output logic              overflow_o
);

  logic [VAL_W-1:0] start_q [MAX_RANGES];
  logic [VAL_W-1:0] end_q   [MAX_RANGES];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] ne_q;
  logic             drop_q, drop_d;
  logic             valid_q;
  logic [VAL_W-1:0] out_start_q, out_end_q;
  logic             out_last_q;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] rd_idx;
  logic [VAL_W-1:0] rd_start, rd_end;
  logic             in_range, full, has_next, touches_next;
  logic             do_insert, do_extend, do_merge;
  logic [VAL_W-1:0] new_start, new_end, merged_end;

  // Single read port: scan position, or its successor during merge
  assign idx_inc  = idx_q + CNT_W'(1);
  assign rd_idx   = cmd_i.merge ? idx_inc : idx_q;
  assign rd_start = start_q[rd_idx[IDX_W-1:0]];
  assign rd_end   = end_q[rd_idx[IDX_W-1:0]];

  // Compares with a +1 run at 33 bits so nothing wraps at the top of the range
  assign in_range = idx_q < cnt_q;
  assign full     = cnt_q == CNT_W'(MAX_RANGES);
  assign has_next = idx_inc < cnt_q;
  assign touches_next = ({1'b0, ne_q} + 33'd1) >= {1'b0, rd_start};

  assign status_o.scan_more = in_range &&
                              (({1'b0, rd_end} + 33'd1) < {1'b0, val_q});
  assign status_o.hit       = in_range &&
                              ({1'b0, rd_start} <= ({1'b0, val_q} + 33'd1));
  assign status_o.last      = idx_inc == cnt_q;

  assign do_extend = cmd_i.resolve && status_o.hit;
  assign do_insert = cmd_i.resolve && !status_o.hit && !full;
  assign do_merge  = cmd_i.merge && has_next && touches_next;

  assign new_start  = (val_q < rd_start) ? val_q : rd_start;
  assign new_end    = (val_q > rd_end) ? val_q : rd_end;
  assign merged_end = (rd_end > ne_q) ? rd_end : ne_q;

  // Index, count and drop flag
  always_comb begin
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (cmd_i.load) begin
      idx_d  = '0;
      drop_d = 1'b0;
    end
    if (cmd_i.step || cmd_i.emit) begin
      idx_d = idx_inc;
    end
    if (cmd_i.resolve && !status_o.hit) begin
      idx_d = '0;
      if (full) begin
        drop_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.merge) begin
      idx_d = '0;
      if (do_merge) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      idx_q   <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      drop_q  <= drop_d;
      valid_q <= cmd_i.emit;
    end
  end

  // Value capture, merged end and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= value_i;
    end
    if (do_extend) begin
      ne_q <= new_end;
    end
    if (cmd_i.emit) begin
      out_start_q <= rd_start;
      out_end_q   <= rd_end;
      out_last_q  <= status_o.last;
    end
  end

  // Per-entry update: each entry sees only itself and its neighbors
  for (genvar gk = 0; gk < MAX_RANGES; gk++) begin : g_entry
    localparam int Prev = (gk > 0) ? gk - 1 : 0;
    localparam int Next = (gk < MAX_RANGES - 1) ? gk + 1 : gk;
    logic at_idx, above_idx;

    assign at_idx    = idx_q == CNT_W'(gk);
    assign above_idx = CNT_W'(gk) > idx_q;

    always_ff @(posedge clk_i) begin
      if (do_insert) begin
        if (at_idx) begin
          start_q[gk] <= val_q;
          end_q[gk]   <= val_q;
        end else if (above_idx) begin
          start_q[gk] <= start_q[Prev];
          end_q[gk]   <= end_q[Prev];
        end
      end else if (do_extend && at_idx) begin
        start_q[gk] <= new_start;
        end_q[gk]   <= new_end;
      end else if (do_merge) begin
        if (at_idx) begin
          end_q[gk] <= merged_end;
        end else if (above_idx) begin
          start_q[gk] <= start_q[Next];
          end_q[gk]   <= end_q[Next];
        end
      end
    end
  end

  assign result_valid_o = valid_q;
  assign range_start_o  = out_start_q;
  assign range_end_o    = out_end_q;
  assign last_range_o   = out_last_q;
  assign overflow_o     = drop_q;

endmodule

// ===== sv/dit_ctrl.sv =====
// Controller: sequences scan, update, merge and table listing for one transaction.
module dit_ctrl
  import dit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  dit_status_t status_i,
  output dit_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_LIST
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_more) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.resolve = 1'b1;
          state_d       = status_i.hit ? ST_MERGE : ST_LIST;
        end
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_LIST;
      end
      ST_LIST: begin
        cmd_o.emit = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

// ===== sv/disjoint_interval_tracker.sv =====
// Top level of the disjoint interval tracker: controller plus datapath.
//
// Usage:
//   Drive value_i and pulse start_i; the transaction is taken at a rising
//   edge where start_i is high and busy_o is low. The block keeps a sorted
//   table of up to MAX_RANGES disjoint, non-adjacent closed intervals.
//   After each transaction it lists the whole table on range_start_o /
//   range_end_o, one interval per cycle marked by result_valid_o, lowest
//   first, with last_range_o on the final one. overflow_o is set on every
//   result of a listing whose value was dropped because the table was full.
// Timing:
//   A transaction loads the value, scans the table up to the scan position
//   (one table entry examined per cycle through a single read port),
//   resolves there, merges when the value hit an existing interval, and then
//   lists the table as it stands after the update (one listed entry per
//   cycle). Each result is registered and appears in the cycle after the
//   listing step that reads it; busy_o drops as the last result is
//   registered. Results cannot be held off by the receiver.
// Reset:
//   rst_ni clears the controller and the interval count; the table is empty.
module disjoint_interval_tracker
  import dit_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [VAL_W-1:0] value_i,
  output logic             result_valid_o,
  output logic [VAL_W-1:0] range_start_o,
  output logic [VAL_W-1:0] range_end_o,
  output logic             last_range_o,
  output logic             overflow_o
);

  dit_cmd_t    cmd;
  dit_status_t status;

  dit_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dit_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .last_range_o   (last_range_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== sv/dit_checker.sv =====
// Port-level checker for the interval tracker, bound to the top level.
`include "assert_macros.svh"

module dit_checker
  import dit_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic [VAL_W-1:0] value_i,
  input logic             result_valid_o,
  input logic [VAL_W-1:0] range_start_o,
  input logic [VAL_W-1:0] range_end_o,
  input logic             last_range_o,
  input logic             overflow_o
);

  logic accept;
  logic mid_list;

  assign accept   = start_i && !busy_o;
  assign mid_list = result_valid_o && !last_range_o;

  // An accepted transaction makes the block busy and produces no result yet
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_o && !result_valid_o)
  // A listing runs without gaps until its last interval
  `ASSERT_NEXT(a_list_contig, clk_i, rst_ni, mid_list, result_valid_o)
  // The last interval closes the listing
  `ASSERT_NEXT(a_list_ends, clk_i, rst_ni, result_valid_o && last_range_o, !result_valid_o)
  // Overflow flag is the same on every result of one listing
  `ASSERT_HOLD(a_ovf_stable, clk_i, rst_ni, mid_list, overflow_o)
  // Intervals are listed in ascending, non-touching order
  `ASSERT_NEXT(a_list_order, clk_i, rst_ni, mid_list,
               ({1'b0, range_start_o} > ({1'b0, $past(range_end_o)} + 33'd1)))

endmodule

bind disjoint_interval_tracker dit_checker u_dit_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .value_i        (value_i),
  .result_valid_o (result_valid_o),
  .range_start_o  (range_start_o),
  .range_end_o    (range_end_o),
  .last_range_o   (last_range_o),
  .overflow_o     (overflow_o)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the disjoint interval tracker: directed and random value streams.
`default_nettype none

module tb_top;
  import dit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One listed interval as it should appear on the result ports
  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic             last;
    logic             ovf;
  } range_rec_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [VAL_W-1:0] value_i;
  logic             result_valid_o;
  logic [VAL_W-1:0] range_start_o;
  logic [VAL_W-1:0] range_end_o;
  logic             last_range_o;
  logic             overflow_o;

  // Shadow interval table
  logic [VAL_W-1:0] lo_tab [MAX_RANGES];
  logic [VAL_W-1:0] hi_tab [MAX_RANGES];
  int               n_ranges;

  range_rec_t       pending_listing [$];
  range_rec_t       listing_head;
  logic [VAL_W-1:0] zone_base;
  int               fail_count;

  disjoint_interval_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .range_start_o (range_start_o),
    .range_end_o   (range_end_o),
    .last_range_o  (last_range_o),
    .overflow_o    (overflow_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Fold one value into the shadow table and queue the listing it produces
  function automatic void absorb_value(input logic [VAL_W-1:0] v);
    int         pos;
    int         k;
    bit         dropped;
    range_rec_t rec;
    pos     = 0;
    dropped = 1'b0;
    // first interval ending at or after v - 1
    while (pos < n_ranges && ({1'b0, hi_tab[pos]} + 33'd1) < {1'b0, v}) pos++;
    if (pos < n_ranges && {1'b0, lo_tab[pos]} <= ({1'b0, v} + 33'd1)) begin
      // inside or touching: extend, then merge with the next one if it now touches
      if (v < lo_tab[pos]) lo_tab[pos] = v;
      if (v > hi_tab[pos]) hi_tab[pos] = v;
      if (pos + 1 < n_ranges &&
          ({1'b0, hi_tab[pos]} + 33'd1) >= {1'b0, lo_tab[pos+1]}) begin
        if (hi_tab[pos+1] > hi_tab[pos]) hi_tab[pos] = hi_tab[pos+1];
        for (k = pos + 1; k + 1 < n_ranges; k++) begin
          lo_tab[k] = lo_tab[k+1];
          hi_tab[k] = hi_tab[k+1];
        end
        n_ranges--;
      end
    end else if (n_ranges < MAX_RANGES) begin
      // new single-value interval, kept in order
      for (k = n_ranges; k > pos; k--) begin
        lo_tab[k] = lo_tab[k-1];
        hi_tab[k] = hi_tab[k-1];
      end
      lo_tab[pos] = v;
      hi_tab[pos] = v;
      n_ranges++;
    end else begin
      dropped = 1'b1;
    end
    for (k = 0; k < n_ranges; k++) begin
      rec.lo   = lo_tab[k];
      rec.hi   = hi_tab[k];
      rec.last = (k + 1 == n_ranges);
      rec.ovf  = dropped;
      pending_listing = {pending_listing, rec};
    end
  endfunction

  // Random value, mostly aimed at the edges and gaps of stored intervals
  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    int k;
    sel = $urandom_range(99);
    if (sel < 15 || n_ranges == 0) return $urandom;
    if (sel < 32) return zone_base + $urandom_range(63);
    k = $urandom_range(n_ranges - 1);
    case ($urandom_range(4))
      0: return lo_tab[k] - 1;
      1: return hi_tab[k] + 1;
      2: return lo_tab[k] + $urandom_range(hi_tab[k] - lo_tab[k]);
      3: return (k + 1 < n_ranges) ? lo_tab[k+1] - 1 : hi_tab[k] + 1;
      default: return ($urandom_range(1) != 0) ? lo_tab[k] : hi_tab[k];
    endcase
  endfunction

  // Present one value and hold it until the transaction is taken
  task automatic send_value(input logic [VAL_W-1:0] v);
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    absorb_value(v);
  endtask

  // Random idle cycles between transactions
  task automatic sender_gap(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct && n < 40) n++;
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop sending until every queued interval has been listed
  task automatic wait_for_listing_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_listing.size() != 0);
  endtask

  // Extremes, extension, merging, and a full table
  task automatic test_directed();
    logic [VAL_W-1:0] seq [$];
    seq = {32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001,
           32'h0000_0000, 32'h0000_0003, 32'h0000_0002, 32'h0000_000A,
           32'h0000_000C, 32'h0000_000B, 32'h7FFF_FFFF,
           // fill up to the table limit
           32'd14, 32'd100, 32'd200, 32'd300, 32'd400, 32'd500, 32'd600,
           32'd700, 32'd800, 32'd900, 32'd1000, 32'd1100,
           // full: drop, extend, merge, insert into the freed slot, then drop again
           32'd5000, 32'd101, 32'd13, 32'd5000, 32'd6000};
    foreach (seq[i]) send_value(seq[i]);
    wait_for_listing_drain();
  endtask

  // Random stream with a given sender idle rate
  task automatic test_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(3))
          0: zone_base = '0;
          1: zone_base = 32'hFFFF_FFC0;
          default: zone_base = $urandom & 32'hFFFF_FFC0;
        endcase
      end
      send_value(pick_value());
      sender_gap(idle_pct);
    end
    wait_for_listing_drain();
  endtask

  // Result checker: each listed interval against the oldest queued one
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_listing.size() == 0) begin
        $error("unexpected result: start %h end %h", range_start_o, range_end_o);
        fail_count++;
      end else begin
        listing_head = pending_listing.pop_front();
        if (range_start_o !== listing_head.lo) begin
          $error("range_start: expected %h, got %h", listing_head.lo, range_start_o);
          fail_count++;
        end
        if (range_end_o !== listing_head.hi) begin
          $error("range_end: expected %h, got %h", listing_head.hi, range_end_o);
          fail_count++;
        end
        if (last_range_o !== listing_head.last) begin
          $error("last_range: expected %b, got %b", listing_head.last, last_range_o);
          fail_count++;
        end
        if (overflow_o !== listing_head.ovf) begin
          $error("overflow: expected %b, got %b", listing_head.ovf, overflow_o);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int waited;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    value_i    = '0;
    n_ranges   = 0;
    zone_base  = '0;
    fail_count = 0;
    waited     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(120, 0);
    test_random(120, 80);
    test_random(110, 13);

    // leftover listings and a quiet tail
    while (pending_listing.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_listing.size() != 0) begin
      $error("%0d listed intervals never arrived", pending_listing.size());
      fail_count++;
    end
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/dit_pkg.sv
sv/dit_datapath.sv
sv/dit_ctrl.sv
sv/disjoint_interval_tracker.sv
sv/dit_checker.sv
sim/tb_top.sv
